// File: design/cfrq_pkg.sv
// Shared types, codes and identifier repacking for the CAN frame receive queue.
// No dependencies.
`timescale 1ns / 1ps

package cfrq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned EXT_BIT   = 3;
  localparam int unsigned RTR_BIT   = 6;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  id;
  } hdr_t;

  function automatic logic [ID_W-1:0] pack_id(
    input logic [7:0] sidh,
    input logic [7:0] sidl,
    input logic [7:0] eid8,
    input logic [7:0] eid0,
    input logic [7:0] dlc
  );
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    if (sidl[EXT_BIT]) begin
      b0 = {1'b1, 2'b00, sidh[7:3]};
      b1 = {sidh[2:0], sidl[7:5], sidl[1:0]};
      b2 = eid8;
      b3 = eid0;
    end else begin
      b0 = 8'h00;
      b1 = 8'h00;
      b2 = {5'b00000, sidh[7:5]};
      b3 = {sidh[4:0], sidl[7:5]};
    end
    b0[RTR_BIT] = dlc[RTR_BIT];
    return {b0, b1, b2, b3};
  endfunction

endpackage

// File: design/cfrq_store.sv
// Frame storage: header and payload memories, one write and one registered read port.
// Depends on cfrq_pkg.
`timescale 1ns / 1ps

module cfrq_store #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]   wr_addr,
  input  cfrq_pkg::hdr_t                   wr_hdr,
  input  logic [cfrq_pkg::DATA_W-1:0]      wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]   rd_addr,
  output cfrq_pkg::hdr_t                   rd_hdr,
  output logic [cfrq_pkg::DATA_W-1:0]      rd_data
);
  import cfrq_pkg::*;

  hdr_t              hdr_mem  [QUEUE_SLOTS];
  logic [DATA_W-1:0] data_mem [QUEUE_SLOTS];
  hdr_t              rd_hdr_r;
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_addr]  <= wr_hdr;
      data_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hdr_r  <= hdr_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

  assign rd_hdr  = rd_hdr_r;
  assign rd_data = rd_data_r;

endmodule

// File: design/can_frame_receive_queue_unit.sv
// Receive queue for CAN frames: pushes repacked, sequence-stamped frames into a ring and pops them.
// Depends on cfrq_pkg and cfrq_store.
// Accepts one transaction per clock while in_stall is low; every transaction gives one result,
// passing through the registered read of the frame memory and the output register.
// The ring holds QUEUE_SLOTS-1 frames; a push into a full ring is dropped, but the
// sequence counter still advances. Clear empties the ring and keeps the counter.
`timescale 1ns / 1ps

module can_frame_receive_queue_unit #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [7:0]                    in_std_id_high,
  input  logic [7:0]                    in_std_id_low,
  input  logic [7:0]                    in_ext_id_mid,
  input  logic [7:0]                    in_ext_id_low,
  input  logic [7:0]                    in_length_reg,
  input  logic [cfrq_pkg::DATA_W-1:0]   in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_valid,
  output logic                          out_dropped,
  output logic [cfrq_pkg::SEQ_W-1:0]    out_sequence_number,
  output logic [cfrq_pkg::ID_W-1:0]     out_packed_id,
  output logic [cfrq_pkg::LEN_W-1:0]    out_length_code,
  output logic [cfrq_pkg::DATA_W-1:0]   out_frame_payload
);
  import cfrq_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);

  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_hit_r, s1_hit_nxt;
  logic              s1_drop_r, s1_drop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic              out_drop_r;
  hdr_t              out_hdr_r;
  logic [DATA_W-1:0] out_data_r;

  logic              in_accept;
  logic              s1_move;
  logic [SLOT_W-1:0] wr_slot_inc;
  logic [SLOT_W-1:0] rd_slot_inc;
  logic              ring_full;
  logic              ring_empty;
  logic              mem_wr_en;
  logic              mem_rd_en;
  hdr_t              mem_wr_hdr;
  hdr_t              mem_rd_hdr;
  logic [DATA_W-1:0] mem_rd_data;

  assign s1_move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall    = s1_valid_r && !s1_move;
  assign in_accept   = in_valid && !in_stall;
  assign wr_slot_inc = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;
  assign rd_slot_inc = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;
  assign ring_full   = (wr_slot_inc == rd_slot_r);
  assign ring_empty  = (rd_slot_r == wr_slot_r);

  assign mem_wr_hdr.seq = seq_r;
  assign mem_wr_hdr.len = in_length_reg[LEN_W-1:0];
  assign mem_wr_hdr.id  = pack_id(in_std_id_high, in_std_id_low, in_ext_id_mid,
                                  in_ext_id_low, in_length_reg);

  always_comb begin
    rd_slot_nxt  = rd_slot_r;
    wr_slot_nxt  = wr_slot_r;
    seq_nxt      = seq_r;
    s1_hit_nxt   = s1_hit_r;
    s1_drop_nxt  = s1_drop_r;
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    s1_valid_nxt = s1_move ? 1'b0 : s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
      s1_hit_nxt   = 1'b0;
      s1_drop_nxt  = 1'b0;
      case (in_operation)
        OP_PUSH: begin
          seq_nxt = seq_r + 1'b1;
          if (ring_full) begin
            s1_drop_nxt = 1'b1;
          end else begin
            mem_wr_en   = 1'b1;
            wr_slot_nxt = wr_slot_inc;
          end
        end
        OP_POP: begin
          if (!ring_empty) begin
            mem_rd_en   = 1'b1;
            s1_hit_nxt  = 1'b1;
            rd_slot_nxt = rd_slot_inc;
          end
        end
        OP_CLEAR: begin
          rd_slot_nxt = '0;
          wr_slot_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    out_valid_nxt = s1_move ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r   <= '0;
      wr_slot_r   <= '0;
      seq_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_slot_r   <= rd_slot_nxt;
      wr_slot_r   <= wr_slot_nxt;
      seq_r       <= seq_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_r  <= s1_hit_nxt;
    s1_drop_r <= s1_drop_nxt;
    if (s1_move) begin
      out_hit_r  <= s1_hit_r;
      out_drop_r <= s1_drop_r;
      out_hdr_r  <= s1_hit_r ? mem_rd_hdr : '0;
      out_data_r <= s1_hit_r ? mem_rd_data : '0;
    end
  end

  cfrq_store #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_slot_r),
    .wr_hdr  (mem_wr_hdr),
    .wr_data (in_payload),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_slot_r),
    .rd_hdr  (mem_rd_hdr),
    .rd_data (mem_rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_frame_valid     = out_hit_r;
  assign out_dropped         = out_drop_r;
  assign out_sequence_number = out_hdr_r.seq;
  assign out_packed_id       = out_hdr_r.id;
  assign out_length_code     = out_hdr_r.len;
  assign out_frame_payload   = out_data_r;

`ifndef NO_ASSERTIONS
  a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation == OP_PUSH) |=> (seq_r == $past(seq_r) + 1'b1))
    else $error("sequence counter did not advance on push");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation == OP_POP && ring_empty) |=> $stable(rd_slot_r))
    else $error("pop from empty ring moved read slot");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted transaction lost before output stage");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_drop_r))
    else $error("result marked both popped and dropped");
`endif

endmodule

// File: test/can_frame_receive_queue_checker.sv
// Checker for the CAN frame receive queue: predicts each result from the input transactions.
// It compares every output transaction field by field. Depends on cfrq_pkg.
`timescale 1ns / 1ps

module can_frame_receive_queue_checker #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [7:0]                    in_std_id_high,
  input  logic [7:0]                    in_std_id_low,
  input  logic [7:0]                    in_ext_id_mid,
  input  logic [7:0]                    in_ext_id_low,
  input  logic [7:0]                    in_length_reg,
  input  logic [cfrq_pkg::DATA_W-1:0]   in_payload,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_frame_valid,
  input  logic                          out_dropped,
  input  logic [cfrq_pkg::SEQ_W-1:0]    out_sequence_number,
  input  logic [cfrq_pkg::ID_W-1:0]     out_packed_id,
  input  logic [cfrq_pkg::LEN_W-1:0]    out_length_code,
  input  logic [cfrq_pkg::DATA_W-1:0]   out_frame_payload,
  output int unsigned                   mismatch_count,
  output int unsigned                   pending_results
);

  import cfrq_pkg::*;

  typedef struct {
    logic              frame_valid;
    logic              dropped;
    logic [SEQ_W-1:0]  seq;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } rx_result_t;

  logic [SEQ_W-1:0]  slot_seq  [QUEUE_SLOTS];
  logic [ID_W-1:0]   slot_id   [QUEUE_SLOTS];
  logic [LEN_W-1:0]  slot_len  [QUEUE_SLOTS];
  logic [DATA_W-1:0] slot_data [QUEUE_SLOTS];
  int unsigned       head_slot;
  int unsigned       tail_slot;
  logic [SEQ_W-1:0]  rx_sequence;
  rx_result_t        awaited_results[$];

  function automatic int unsigned advance_slot(input int unsigned slot);
    return (slot + 1 >= QUEUE_SLOTS) ? 0 : slot + 1;
  endfunction

  // The 29-bit extended or 11-bit standard identifier sits below the extended and RTR flags.
  function automatic logic [ID_W-1:0] repack_identifier(
    input logic [7:0] sidh,
    input logic [7:0] sidl,
    input logic [7:0] eid8,
    input logic [7:0] eid0,
    input logic [7:0] dlc
  );
    if (sidl[EXT_BIT]) begin
      return {1'b1, dlc[RTR_BIT], 1'b0, sidh, sidl[7:5], sidl[1:0], eid8, eid0};
    end
    return {1'b0, dlc[RTR_BIT], 19'd0, sidh, sidl[7:5]};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic predict_transaction();
    rx_result_t  r;
    int unsigned nxt;
    r = '{default: '0};
    case (in_operation)
      OP_PUSH: begin
        nxt = advance_slot(tail_slot);
        if (nxt != head_slot) begin
          slot_seq[tail_slot]  = rx_sequence;
          slot_len[tail_slot]  = in_length_reg[3:0];
          slot_id[tail_slot]   = repack_identifier(in_std_id_high, in_std_id_low,
                                                   in_ext_id_mid, in_ext_id_low,
                                                   in_length_reg);
          slot_data[tail_slot] = in_payload;
          tail_slot = nxt;
        end else begin
          r.dropped = 1'b1;
        end
        rx_sequence = rx_sequence + 1'b1;
      end
      OP_POP: begin
        if (head_slot != tail_slot) begin
          r.frame_valid = 1'b1;
          r.seq  = slot_seq[head_slot];
          r.id   = slot_id[head_slot];
          r.len  = slot_len[head_slot];
          r.data = slot_data[head_slot];
          head_slot = advance_slot(head_slot);
        end
      end
      OP_CLEAR: begin
        head_slot = 0;
        tail_slot = 0;
      end
      default: ;
    endcase
    awaited_results.push_back(r);
  endtask

  task automatic check_result();
    rx_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("transaction with nothing pending", 64'd1, 64'd0);
      return;
    end
    want = awaited_results.pop_front();
    if (out_frame_valid !== want.frame_valid)
      report_mismatch("frame_valid", 64'(out_frame_valid), 64'(want.frame_valid));
    if (out_dropped !== want.dropped)
      report_mismatch("dropped", 64'(out_dropped), 64'(want.dropped));
    if (out_sequence_number !== want.seq)
      report_mismatch("sequence_number", 64'(out_sequence_number), 64'(want.seq));
    if (out_packed_id !== want.id)
      report_mismatch("packed_id", 64'(out_packed_id), 64'(want.id));
    if (out_length_code !== want.len)
      report_mismatch("length_code", 64'(out_length_code), 64'(want.len));
    if (out_frame_payload !== want.data)
      report_mismatch("frame_payload", out_frame_payload, want.data);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot      = 0;
      tail_slot      = 0;
      rx_sequence    = '0;
      mismatch_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_transaction();
    end
    pending_results = awaited_results.size();
  end

endmodule

// File: test/testbench.sv
// Top of the CAN frame receive queue testbench: clock, reset, stimulus and verdict.
// Depends on cfrq_pkg, can_frame_receive_queue_unit and can_frame_receive_queue_checker.
`timescale 1ns / 1ps

module testbench;

  import cfrq_pkg::*;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned MAX_CYCLES  = 3_000_000;
  localparam logic [1:0]  OP_RESERVED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = OP_PUSH;
  logic [7:0]        in_std_id_high = '0;
  logic [7:0]        in_std_id_low = '0;
  logic [7:0]        in_ext_id_mid = '0;
  logic [7:0]        in_ext_id_low = '0;
  logic [7:0]        in_length_reg = '0;
  logic [DATA_W-1:0] in_payload = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic              out_frame_valid;
  logic              out_dropped;
  logic [SEQ_W-1:0]  out_sequence_number;
  logic [ID_W-1:0]   out_packed_id;
  logic [LEN_W-1:0]  out_length_code;
  logic [DATA_W-1:0] out_frame_payload;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned recv_wait = 0;
  bit          quiet_mode = 1'b0;
  logic        out_taken = 1'b0;

  can_frame_receive_queue_unit #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_top (.*);

  can_frame_receive_queue_checker #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) out_taken <= rst_n && out_valid && !out_stall;

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (out_taken) recv_wait = quiet_mode ? 0 : $urandom_range(0, 13);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (recv_wait > 0);
      if (recv_wait > 0 && out_valid) recv_wait--;
    end
  end

  task automatic send_transaction(
    input logic [1:0]        op,
    input logic [7:0]        sidh,
    input logic [7:0]        sidl,
    input logic [7:0]        eid8,
    input logic [7:0]        eid0,
    input logic [7:0]        dlc,
    input logic [DATA_W-1:0] data
  );
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_std_id_high <= sidh;
    in_std_id_low  <= sidl;
    in_ext_id_mid  <= eid8;
    in_ext_id_low  <= eid0;
    in_length_reg  <= dlc;
    in_payload     <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input logic [1:0] op);
    send_transaction(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), {$urandom, $urandom});
  endtask

  function automatic logic [1:0] pick_operation(input int unsigned push_pct,
                                                input int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return OP_PUSH;
    if (r < push_pct + pop_pct) return OP_POP;
    if (r < 98) return OP_CLEAR;
    return OP_RESERVED;
  endfunction

  // Leaves the input idle and returns at a rising edge.
  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned push_pct;
    int unsigned pop_pct;
    logic [1:0]  op;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_transaction(OP_POP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    send_transaction(OP_RESERVED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1);
    send_transaction(OP_PUSH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    send_transaction(OP_PUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1);
    send_transaction(OP_PUSH, 8'hFF, 8'hE7, 8'hFF, 8'hFF, 8'h4F,
                     64'h0123_4567_89AB_CDEF);
    send_transaction(OP_PUSH, 8'h00, 8'h08, 8'h5A, 8'hA5, 8'h0F,
                     64'hAAAA_AAAA_5555_5555);
    send_transaction(OP_PUSH, 8'h80, 8'h20, 8'h00, 8'h00, 8'hB0,
                     64'h8000_0000_0000_0001);
    repeat (6) send_transaction(OP_POP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    repeat (2) send_random(OP_PUSH);
    send_random(OP_CLEAR);
    send_random(OP_POP);
    send_transaction(OP_RESERVED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    send_random(OP_PUSH);
    send_random(OP_POP);

    for (int phase = 0; phase < 10; phase++) begin
      hold_input();
      quiet_mode = (phase == 3) || ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       begin push_pct = 75; pop_pct = 19; end
        1:       begin push_pct = 25; pop_pct = 69; end
        default: begin push_pct = 47; pop_pct = 47; end
      endcase
      if (phase == 3) begin
        push_pct = 80;
        pop_pct  = 14;
      end
      sent = 0;
      while (sent < 200) begin
        op = pick_operation(push_pct, pop_pct);
        send_random(op);
        if (op != OP_RESERVED) sent++;
        // stall the result side long enough to back up into the input
        if (phase == 3 && sent == 1) hold_request = 400;
      end
      if (phase == 5 || $urandom_range(0, 2) == 0) drain_results();
    end

    hold_input();
    quiet_mode = 1'b0;
    for (int n = 0; n < 100; n++) send_random(pick_operation(50, 44));

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
design/cfrq_pkg.sv
design/cfrq_store.sv
design/can_frame_receive_queue_unit.sv
test/can_frame_receive_queue_checker.sv
test/testbench.sv
